// File: hw/rtl/pcrl_pkg.sv
// ----------------------------------------------------------------------------
// Rate limiter package
// Shared types, codes and reset values for the per-client rate limiter.
// ----------------------------------------------------------------------------
package pcrl_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int MS_PER_SECOND   = 1000;
  localparam int MS_W            = 10;

  localparam logic [15:0] REQUEST_LIMIT_RST  = 16'd20;
  localparam logic [15:0] WINDOW_LENGTH_RST  = 16'd1000;
  localparam logic [15:0] BLOCK_SECONDS_RST  = 16'd5;
  localparam logic [5:0]  ENTRIES_IN_USE_RST = 6'd32;

  localparam logic FUNC_CHECK = 1'b0;
  localparam logic FUNC_RESET = 1'b1;

  typedef enum logic [1:0] {
    CFG_REQUEST_LIMIT,
    CFG_WINDOW_LENGTH,
    CFG_BLOCK_SECONDS,
    CFG_ENTRIES_IN_USE
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OUT_NEW_ENTRY,
    OUT_NEW_WINDOW,
    OUT_IN_WINDOW,
    OUT_TABLE_FULL,
    OUT_STILL_BLOCKED,
    OUT_LIMIT_EXCEEDED,
    OUT_RESET_DONE,
    OUT_RESET_UNKNOWN
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [16:0] count;
    logic [31:0] win_base;
    logic        blocked;
    logic [31:0] hold_until;
  } entry_t;

endpackage

// File: hw/rtl/per_client_fixed_window_rate_limiter.sv
// ----------------------------------------------------------------------------
// Per-client fixed-window rate limiter
// Keyed table walk over the entry RAM, then a decide state and a write state.
// ----------------------------------------------------------------------------
// done rises after the table walk over span = min(entries_in_use, TABLE_DEPTH) entries,
// followed by the decide state and the write state.
// A new word is taken only while idle; the next start is taken while done is high.
// done is a one-cycle strobe; the receiver cannot stall; cfg_ready is low while busy.
// Reset (rst, synchronous) clears the valid bits, counters, config registers and state; no clearing pass.
module per_client_fixed_window_rate_limiter #(
  parameter int TABLE_DEPTH = pcrl_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [31:0] client_addr,
  input  logic [31:0] now_ms,
  output logic        done,
  output logic        allowed,
  output logic [2:0]  outcome,
  output logic [31:0] hit_total,
  output logic [31:0] deny_total,
  output logic [5:0]  live_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import pcrl_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW    = (CNT_W > 6) ? CNT_W : 6;
  localparam int ENT_W = $bits(entry_t);

  state_t state, state_next;

  logic [15:0] request_limit;
  logic [15:0] window_length_ms;
  logic [15:0] block_seconds;
  logic [5:0]  entries_in_use;

  logic [TABLE_DEPTH-1:0] used;
  logic [31:0] hit_counter;
  logic [31:0] denied_counter;

  logic        func_r;
  logic [31:0] key_r;
  logic [31:0] now_r;
  logic [15+MS_W:0] block_ms;

  logic [CNT_W-1:0] scan_idx;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [SW-1:0]    act_cnt;
  entry_t           rec;

  logic             upd_we;
  logic             upd_alloc;
  logic             upd_block;
  logic [IDX_W-1:0] upd_idx;
  entry_t           upd_rec;
  logic             upd_allowed;
  outcome_t         upd_outcome;

  logic             dec_we;
  logic             dec_alloc;
  logic             dec_block;
  logic [IDX_W-1:0] dec_idx;
  entry_t           dec_rec;
  logic             dec_allowed;
  logic             dec_hit;
  logic             dec_deny;
  outcome_t         dec_outcome;

  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;
  entry_t           ram_wdata;
  entry_t           rd_entry;

  logic [SW-1:0]    eiu_ext;
  logic [SW-1:0]    span_ext;
  logic [CNT_W-1:0] span;
  logic             scan_more;
  logic             accept;

  logic [31:0] live_diff;
  logic [31:0] base_ws;
  logic [16:0] base_count;
  logic [31:0] elapsed;
  logic [16:0] cnt_inc;
  logic        live;
  logic        win_over;
  logic        over;

  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign rd_entry  = entry_t'(ram_rdata);

  assign eiu_ext   = SW'(entries_in_use);
  assign span_ext  = (eiu_ext > SW'(TABLE_DEPTH)) ? SW'(TABLE_DEPTH) : eiu_ext;
  assign span      = span_ext[CNT_W-1:0];
  assign scan_more = scan_idx < span;

  pcrl_ram #(
    .WIDTH (ENT_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (upd_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      request_limit    <= REQUEST_LIMIT_RST;
      window_length_ms <= WINDOW_LENGTH_RST;
      block_seconds    <= BLOCK_SECONDS_RST;
      entries_in_use   <= ENTRIES_IN_USE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_REQUEST_LIMIT:  request_limit    <= cfg_data;
        CFG_WINDOW_LENGTH:  window_length_ms <= cfg_data;
        CFG_BLOCK_SECONDS:  block_seconds    <= cfg_data;
        CFG_ENTRIES_IN_USE: entries_in_use   <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (!scan_more && !cmp_vld) state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_WRITE;
      ST_WRITE:  state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state != ST_IDLE);
    ram_raddr = scan_idx[IDX_W-1:0];
    ram_we    = (state == ST_WRITE) && upd_we;
    ram_wdata = upd_rec;
    if (upd_block) begin
      ram_wdata.hold_until = now_r + 32'(block_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= func;
      key_r    <= client_addr;
      now_r    <= now_ms;
    end
    if (state == ST_DECIDE) begin
      block_ms <= (16+MS_W)'(block_seconds) * (16+MS_W)'(MS_PER_SECOND);
    end
  end

  // walk the table: issue one read a cycle, compare the word read the cycle before
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld    <= 1'b0;
      scan_idx   <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      act_cnt    <= '0;
    end else if (accept) begin
      cmp_vld    <= 1'b0;
      scan_idx   <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      act_cnt    <= '0;
    end else if (state == ST_SCAN) begin
      cmp_vld <= scan_more;
      cmp_idx <= scan_idx[IDX_W-1:0];
      if (scan_more) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end
      if (cmp_vld) begin
        if (used[cmp_idx]) begin
          act_cnt <= act_cnt + SW'(1);
          if (!found && rd_entry.key == key_r) begin
            found   <= 1'b1;
            hit_idx <= cmp_idx;
            rec     <= rd_entry;
          end
        end else if (!free_found) begin
          free_found <= 1'b1;
          free_idx   <= cmp_idx;
        end
      end
    end
  end

  always_comb begin
    live_diff  = now_r - rec.hold_until;
    live       = rec.blocked && live_diff[31];
    base_count = rec.blocked ? 17'd0 : rec.count;
    base_ws    = rec.blocked ? now_r : rec.win_base;
    elapsed    = now_r - base_ws;
    win_over   = elapsed > {16'd0, window_length_ms};
    cnt_inc    = base_count + 17'd1;
    over       = cnt_inc > {1'b0, request_limit};

    dec_we      = 1'b0;
    dec_alloc   = 1'b0;
    dec_block   = 1'b0;
    dec_idx     = hit_idx;
    dec_rec     = rec;
    dec_allowed = 1'b0;
    dec_hit     = 1'b0;
    dec_deny    = 1'b0;
    dec_outcome = OUT_RESET_UNKNOWN;

    if (func_r == FUNC_RESET) begin
      if (found) begin
        dec_we           = 1'b1;
        dec_rec.count    = '0;
        dec_rec.win_base = now_r;
        dec_rec.blocked  = 1'b0;
        dec_outcome      = OUT_RESET_DONE;
      end
    end else begin
      dec_hit = 1'b1;
      if (!found && !free_found) begin
        dec_deny    = 1'b1;
        dec_outcome = OUT_TABLE_FULL;
      end else if (!found) begin
        dec_we      = 1'b1;
        dec_alloc   = 1'b1;
        dec_idx     = free_idx;
        dec_rec     = '{key: key_r, count: 17'd1, win_base: now_r,
                        blocked: 1'b0, hold_until: 32'd0};
        dec_allowed = 1'b1;
        dec_outcome = OUT_NEW_ENTRY;
      end else if (live) begin
        dec_deny    = 1'b1;
        dec_outcome = OUT_STILL_BLOCKED;
      end else if (win_over) begin
        dec_we           = 1'b1;
        dec_rec.count    = 17'd1;
        dec_rec.win_base = now_r;
        dec_rec.blocked  = 1'b0;
        dec_allowed      = 1'b1;
        dec_outcome      = OUT_NEW_WINDOW;
      end else begin
        dec_we           = 1'b1;
        dec_rec.count    = cnt_inc;
        dec_rec.win_base = base_ws;
        dec_rec.blocked  = over;
        if (over) begin
          dec_block   = 1'b1;
          dec_deny    = 1'b1;
          dec_outcome = OUT_LIMIT_EXCEEDED;
        end else begin
          dec_allowed = 1'b1;
          dec_outcome = OUT_IN_WINDOW;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DECIDE) begin
      upd_we      <= dec_we;
      upd_alloc   <= dec_alloc;
      upd_block   <= dec_block;
      upd_idx     <= dec_idx;
      upd_rec     <= dec_rec;
      upd_allowed <= dec_allowed;
      upd_outcome <= dec_outcome;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used           <= '0;
      hit_counter    <= '0;
      denied_counter <= '0;
      done           <= 1'b0;
    end else begin
      done <= (state == ST_WRITE);
      if (state == ST_DECIDE) begin
        hit_counter    <= hit_counter + 32'(dec_hit);
        denied_counter <= denied_counter + 32'(dec_deny);
      end
      if (state == ST_WRITE && upd_alloc) begin
        used[upd_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_WRITE) begin
      allowed    <= upd_allowed;
      outcome    <= upd_outcome;
      hit_total  <= hit_counter;
      deny_total <= denied_counter;
      live_count <= 6'(act_cnt + SW'(upd_alloc));
    end
  end

`ifndef ASSERT_OFF
  a_done_after_write: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_WRITE)
    else $error("done without a write cycle");

  a_accept_scans: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN)
    else $error("accepted word did not start a table walk");

  a_compare_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    state != ST_SCAN |-> !cmp_vld)
    else $error("compare stage active outside the table walk");

  a_alloc_free_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE && upd_alloc) |-> !used[upd_idx])
    else $error("allocation over a used entry");

  a_allowed_outcome: assert property (@(posedge clk) disable iff (rst)
    (done && allowed) |-> (outcome == OUT_NEW_ENTRY || outcome == OUT_NEW_WINDOW ||
                           outcome == OUT_IN_WINDOW))
    else $error("allowed with a denying outcome");
`endif

endmodule

// File: hw/rtl/pcrl_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module pcrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
